>>> sv/mpf_pkg.sv
package mpf_pkg;

  // default sizing of the line memory and the position counters
  localparam int unsigned DEF_MAX_POOL     = 4;
  localparam int unsigned DEF_MAX_WIDTH    = 64;
  localparam int unsigned DEF_MAX_CHANNELS = 16;
  localparam int unsigned DEF_MAX_HEIGHT   = 1024;

  // fixed field widths
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned OROW_W  = 10;
  localparam int unsigned OCOL_W  = 6;
  localparam int unsigned OCH_W   = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned HEIGHT_W = 11;
  localparam int unsigned WIDTH_W  = 7;
  localparam int unsigned CHANS_W  = 5;
  localparam int unsigned POOL_W   = 3;
  localparam int unsigned STRIDE_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_STRIDE = 3'd4;

  // register reset values
  localparam logic [HEIGHT_W-1:0] RST_IN_HEIGHT   = 11'd28;
  localparam logic [WIDTH_W-1:0]  RST_IN_WIDTH    = 7'd28;
  localparam logic [CHANS_W-1:0]  RST_CHANNELS    = 5'd1;
  localparam logic [POOL_W-1:0]   RST_POOL_SIZE   = 3'd2;
  localparam logic [STRIDE_W-1:0] RST_POOL_STRIDE = 3'd2;

endpackage

>>> sv/mpf_ram.sv
module mpf_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/max_pool_forward_stream.sv
// channel   direction  handshake              payload
// in        sink       in_valid_i/in_stall_o   sample_value_i
// out       source     out_valid_o/out_stall_i pooled_value_o, out_row_o, out_col_o,
//                                              out_channel_o, last_of_image_o
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a sample that closes no window leaves the input free; a sample that closes a window
// stalls the input for a walk with one line memory read per window element
// through the single read port, plus any wait for the output register to free.
// reset clears counters, control and output valid and loads default registers;
// the line memory is not cleared, a window only reads rows of the current image.
// a stalled result waits in the output register while the next word is taken.
module max_pool_forward_stream
  import mpf_pkg::*;
#(
  parameter int unsigned MAX_POOL     = DEF_MAX_POOL,
  parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int unsigned MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int unsigned MAX_HEIGHT   = DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [VALUE_W-1:0] sample_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] pooled_value_o,
  output logic [OROW_W-1:0]         out_row_o,
  output logic [OCOL_W-1:0]         out_col_o,
  output logic [OCH_W-1:0]          out_channel_o,
  output logic                      last_of_image_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH = MAX_POOL * MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int unsigned PW    = $clog2(MAX_POOL + 1);
  localparam int unsigned XW    = PW + 1;
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HEW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WEW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NEW_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned RTW   = RW + 4;
  localparam int unsigned CTW   = CW + 4;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // configuration registers
  logic [HEIGHT_W-1:0] in_height_q;
  logic [WIDTH_W-1:0]  in_width_q;
  logic [CHANS_W-1:0]  channels_q;
  logic [POOL_W-1:0]   pool_size_q;
  logic [STRIDE_W-1:0] pool_stride_q;

  // effective dimensions
  logic [HEW-1:0]      h_eff;
  logic [WEW-1:0]      w_eff;
  logic [NEW_W-1:0]    nc_eff;
  logic [PW-1:0]       p_eff;
  logic [STRIDE_W-1:0] s_eff;

  // stream position
  logic [RW-1:0] row_q, row_d, orow_q, orow_d;
  logic [CW-1:0] col_q, col_d, ocol_q, ocol_d;
  logic [HW-1:0] chan_q, chan_d;
  logic [SW-1:0] slot_q, slot_d;

  logic          in_acc, cfg_wr, cfg_hit;
  logic [RTW-1:0] row_tgt;
  logic [CTW-1:0] col_tgt;
  logic          row_hit, col_hit, win_hit, win_last;
  logic [XW-1:0] base_slot_x;
  logic [CW+PW-1:0] base_col_x;

  // window walk
  logic [1:0]    state_q, state_d;
  logic [PW-1:0] wi_q, wi_d, wk_q, wk_d;
  logic [SW-1:0] wslot_q, wslot_d;
  logic [CW-1:0] wcol_q, wcol_d, bcol_q;
  logic [HW-1:0] wch_q;
  logic [RW-1:0] lrow_q;
  logic [CW-1:0] lcol_q;
  logic          llast_q;
  logic          rd_pend_q, first_q, first_d;
  logic signed [VALUE_W-1:0] best_q, best_d, rd_val;
  logic          rd_en, out_free, out_load;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [VALUE_W-1:0] rd_data;

  // output register
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_val_q;
  logic [OROW_W-1:0]         out_row_q;
  logic [OCOL_W-1:0]         out_col_q;
  logic [OCH_W-1:0]          out_ch_q;
  logic                      out_last_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign cfg_hit     = cfg_wr && (cfg_index_i == REG_IN_HEIGHT || cfg_index_i == REG_IN_WIDTH ||
                       cfg_index_i == REG_CHANNELS || cfg_index_i == REG_POOL_SIZE ||
                       cfg_index_i == REG_POOL_STRIDE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q   <= RST_IN_HEIGHT;
      in_width_q    <= RST_IN_WIDTH;
      channels_q    <= RST_CHANNELS;
      pool_size_q   <= RST_POOL_SIZE;
      pool_stride_q <= RST_POOL_STRIDE;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_IN_HEIGHT:   in_height_q   <= cfg_data_i[HEIGHT_W-1:0];
        REG_IN_WIDTH:    in_width_q    <= cfg_data_i[WIDTH_W-1:0];
        REG_CHANNELS:    channels_q    <= cfg_data_i[CHANS_W-1:0];
        REG_POOL_SIZE:   pool_size_q   <= cfg_data_i[POOL_W-1:0];
        REG_POOL_STRIDE: pool_stride_q <= cfg_data_i[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp each dimension to its legal range
  always_comb begin
    if (in_height_q == '0) begin
      h_eff = HEW'(1);
    end else if (32'(in_height_q) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(in_height_q);
    end
    if (in_width_q == '0) begin
      w_eff = WEW'(1);
    end else if (32'(in_width_q) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(in_width_q);
    end
    if (channels_q == '0) begin
      nc_eff = NEW_W'(1);
    end else if (32'(channels_q) > MAX_CHANNELS) begin
      nc_eff = NEW_W'(MAX_CHANNELS);
    end else begin
      nc_eff = NEW_W'(channels_q);
    end
    if (pool_size_q == '0) begin
      p_eff = PW'(1);
    end else if (32'(pool_size_q) > MAX_POOL) begin
      p_eff = PW'(MAX_POOL);
    end else begin
      p_eff = PW'(pool_size_q);
    end
    s_eff = (pool_stride_q == '0) ? STRIDE_W'(1) : pool_stride_q;
  end

  // next window corner row and column from the output counters
  assign row_tgt = RTW'(p_eff) - RTW'(1) + RTW'(orow_q) * RTW'(s_eff);
  assign col_tgt = CTW'(p_eff) - CTW'(1) + CTW'(ocol_q) * CTW'(s_eff);
  assign row_hit = (RTW'(row_q) == row_tgt);
  assign col_hit = (CTW'(col_q) == col_tgt);
  assign win_hit = row_hit & col_hit;

  // no further window fits below or to the right
  assign win_last = (RTW'(row_q) + RTW'(s_eff) >= RTW'(h_eff)) &&
                    (CTW'(col_q) + CTW'(s_eff) >= CTW'(w_eff)) &&
                    (NEW_W'(chan_q) == nc_eff - NEW_W'(1));

  // window origin in the ring
  assign base_slot_x = (XW'(slot_q) >= XW'(p_eff) - XW'(1)) ?
                       XW'(slot_q) - (XW'(p_eff) - XW'(1)) :
                       XW'(slot_q) + XW'(MAX_POOL) - (XW'(p_eff) - XW'(1));
  assign base_col_x  = (CW+PW)'(col_q) - ((CW+PW)'(p_eff) - (CW+PW)'(1));

  // position counters
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    chan_d = chan_q;
    orow_d = orow_q;
    ocol_d = ocol_q;
    slot_d = slot_q;
    if (cfg_hit) begin
      row_d  = '0;
      col_d  = '0;
      chan_d = '0;
      orow_d = '0;
      ocol_d = '0;
      slot_d = '0;
    end else if (in_acc) begin
      if (NEW_W'(chan_q) + NEW_W'(1) == nc_eff) begin
        chan_d = '0;
        if (col_hit) begin
          ocol_d = ocol_q + CW'(1);
        end
        if (WEW'(col_q) + WEW'(1) == w_eff) begin
          col_d  = '0;
          ocol_d = '0;
          if (HEW'(row_q) + HEW'(1) == h_eff) begin
            row_d  = '0;
            orow_d = '0;
            slot_d = '0;
          end else begin
            row_d  = row_q + RW'(1);
            slot_d = (slot_q == SW'(MAX_POOL - 1)) ? '0 : slot_q + SW'(1);
            if (row_hit) begin
              orow_d = orow_q + RW'(1);
            end
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end else begin
        chan_d = chan_q + HW'(1);
      end
    end
  end

  // walk sequencer and running maximum
  assign rd_val   = $signed(rd_data);
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign rd_en    = (state_q == ST_WALK);
  assign out_load = (state_q == ST_DONE) & out_free;

  always_comb begin
    state_d = state_q;
    wi_d    = wi_q;
    wk_d    = wk_q;
    wslot_d = wslot_q;
    wcol_d  = wcol_q;
    first_d = first_q;
    best_d  = best_q;
    if (rd_pend_q) begin
      first_d = 1'b0;
      if (first_q || rd_val > best_q) begin
        best_d = rd_val;
      end
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc && win_hit) begin
          state_d = ST_WALK;
          wi_d    = '0;
          wk_d    = '0;
          wslot_d = SW'(base_slot_x);
          wcol_d  = CW'(base_col_x);
          first_d = 1'b1;
        end
      end
      ST_WALK: begin
        if (wk_q == p_eff - PW'(1)) begin
          wk_d    = '0;
          wcol_d  = bcol_q;
          wslot_d = (wslot_q == SW'(MAX_POOL - 1)) ? '0 : wslot_q + SW'(1);
          if (wi_q == p_eff - PW'(1)) begin
            state_d = ST_DRAIN;
          end else begin
            wi_d = wi_q + PW'(1);
          end
        end else begin
          wk_d   = wk_q + PW'(1);
          wcol_d = wcol_q + CW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      chan_q      <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      slot_q      <= '0;
      wi_q        <= '0;
      wk_q        <= '0;
      rd_pend_q   <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      chan_q    <= chan_d;
      orow_q    <= orow_d;
      ocol_q    <= ocol_d;
      slot_q    <= slot_d;
      wi_q      <= wi_d;
      wk_q      <= wk_d;
      rd_pend_q <= rd_en;
      first_q   <= first_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk data and result payload
  always_ff @(posedge clk_i) begin
    wslot_q <= wslot_d;
    wcol_q  <= wcol_d;
    best_q  <= best_d;
    if (state_q == ST_IDLE && in_acc && win_hit) begin
      bcol_q  <= CW'(base_col_x);
      wch_q   <= chan_q;
      lrow_q  <= orow_q;
      lcol_q  <= ocol_q;
      llast_q <= win_last;
    end
    if (out_load) begin
      out_val_q  <= best_q;
      out_row_q  <= OROW_W'(lrow_q);
      out_col_q  <= OCOL_W'(lcol_q);
      out_ch_q   <= OCH_W'(wch_q);
      out_last_q <= llast_q;
    end
  end

  // line memory addressing: slot, then column, then channel
  assign wr_addr = AW'((32'(slot_q) * MAX_WIDTH + 32'(col_q)) * MAX_CHANNELS + 32'(chan_q));
  assign rd_addr = AW'((32'(wslot_q) * MAX_WIDTH + 32'(wcol_q)) * MAX_CHANNELS + 32'(wch_q));

  mpf_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW),
    .DATA_W (VALUE_W)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc),
    .wr_addr_i (wr_addr),
    .wr_data_i (sample_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o     = out_valid_q;
  assign pooled_value_o  = out_val_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign out_channel_o   = out_ch_q;
  assign last_of_image_o = out_last_q;

endmodule

>>> sv/mpf_checker.sv
module mpf_checker
  import mpf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [VALUE_W-1:0] pooled_value_o,
  input logic [OROW_W-1:0]  out_row_o,
  input logic [OCOL_W-1:0]  out_col_o,
  input logic [OCH_W-1:0]   out_channel_o,
  input logic               last_of_image_o
);

  // busy only after a word was taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted word");

  // a fresh result only comes out of a window walk
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |-> $past(in_stall_o))
    else $error("result word appeared without a window walk");

  // a walk that ends has delivered its result
  a_walk_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> !$past(in_stall_o, 2) || $past(out_valid_o) || out_valid_o)
    else $error("walk ended without delivering a result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pooled_value_o) &&
      $stable(out_row_o) && $stable(out_col_o) && $stable(out_channel_o) &&
      $stable(last_of_image_o)))
    else $error("stalled result word changed");

endmodule

bind max_pool_forward_stream mpf_checker u_mpf_checker (.*);
